FILE: src/ptsa_pkg.sv
// shared types and constants for the pointer trajectory meter
package ptsa_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int DUR_W  = 34;
    localparam int EVT_W  = 16;
    localparam int SEC_W  = 32;
    localparam int NSEC_W = 30;
    localparam int SPD_W  = 40;
    localparam int ACC_W  = 18;
    localparam int IDX_W  = 2;

    localparam logic [DUR_W-1:0] MAX_DUR_RST = 34'd10000000000;
    localparam logic [DUR_W-1:0] MIN_DUR_RST = 34'd1000000000;
    localparam logic [EVT_W-1:0] MAX_EVT_RST = 16'd100;
    localparam logic [29:0]      NS_PER_SEC  = 30'd1000000000;
    localparam logic [ACC_W-1:0] ONE_Q16     = 18'sd65536;

    localparam logic [IDX_W-1:0] REG_MAX_DUR = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN_DUR = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_EVT = 2'd2;

    localparam logic [1:0] KIND_MOVE = 2'd0;

    // one queued job for the back end
    typedef struct packed {
        logic        do_step;      // add a step length
        logic        do_report;    // compute speed/accuracy and emit
        logic        do_end;       // trajectory ends with this event
        logic [65:0] radicand;     // dx^2+dy^2 (unshifted)
        logic [63:0] elapsed;      // non-negative ns when reporting
        logic        elapsed_pos;
        logic        any_moves;    // move pairs > 0 after this event
        logic [15:0] move_pairs;
        logic [15:0] reversals;
    } t_job;

endpackage

FILE: src/ptsa_front.sv
// front end: trajectory bookkeeping, classification and job generation
module ptsa_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_event_kind,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic [31:0]                   i_stamp_sec,
    input  logic [29:0]                   i_stamp_nsec,
    input  logic [ptsa_pkg::DUR_W-1:0]    i_max_dur,
    input  logic [ptsa_pkg::DUR_W-1:0]    i_min_dur,
    input  logic [ptsa_pkg::EVT_W-1:0]    i_max_evt,
    output logic                          o_job_valid,
    output ptsa_pkg::t_job                o_job,
    input  logic                          i_job_full
);
    import ptsa_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    logic [1:0]  r_kind;
    logic signed [COORD_WIDTH-1:0] r_x, r_y;

    logic [15:0] r_total;
    logic [31:0] r_first_sec;
    logic [29:0] r_first_nsec;
    logic [1:0]  r_last_kind;
    logic signed [COORD_WIDTH-1:0] r_lx, r_ly, r_bx, r_by;
    logic [15:0] r_pairs, r_revs;

    // stage registers
    logic [DW-2:0] r_adx, r_ady;
    logic signed [32:0] r_dsec;
    logic signed [31:0] r_dnsec;
    logic        r_step;
    logic [65:0] r_sq;
    logic signed [63:0] r_elapsed;

    logic signed [DW-1:0] dx1, dy1, dx0, dy0;
    logic opp;

    assign dx1 = DW'(i_pos_x) - DW'(r_lx);
    assign dy1 = DW'(i_pos_y) - DW'(r_ly);
    assign dx0 = DW'(r_lx) - DW'(r_bx);
    assign dy0 = DW'(r_ly) - DW'(r_by);
    assign opp = ((dx1 < 0) && (dx0 > 0)) || ((dx1 > 0) && (dx0 < 0))
              || ((dy1 < 0) && (dy0 > 0)) || ((dy1 > 0) && (dy0 < 0));

    assign o_stall = (r_state != S_IDLE);

    logic [15:0] n_cnt;
    logic done, report;
    assign n_cnt = r_total;  // already incremented in S_MUL
    assign done = (r_kind != KIND_MOVE)
               || (r_elapsed > $signed({30'd0, i_max_dur}))
               || (n_cnt >= i_max_evt);
    assign report = done && (r_elapsed >= $signed({30'd0, i_min_dur})) && (n_cnt > 16'd1);

    // an ending trajectory always reaches the back end so its distance is cleared
    assign o_job_valid = (r_state == S_DONE) && !i_job_full && (r_step || done);
    always_comb begin
        o_job.do_step     = r_step;
        o_job.do_report   = report;
        o_job.do_end      = done;
        o_job.radicand    = r_sq;
        o_job.elapsed     = r_elapsed;
        o_job.elapsed_pos = (r_elapsed > 0);
        o_job.any_moves   = (r_pairs != 16'd0);
        o_job.move_pairs  = r_pairs;
        o_job.reversals   = r_revs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0; r_first_sec <= '0; r_first_nsec <= '0;
            r_last_kind <= '0; r_lx <= '0; r_ly <= '0; r_bx <= '0; r_by <= '0;
            r_pairs <= '0; r_revs <= '0; r_step <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_kind <= i_event_kind;
                        r_x <= i_pos_x; r_y <= i_pos_y;
                        r_step <= 1'b0;
                        if (r_total == 16'd0) begin
                            r_first_sec <= i_stamp_sec;
                            r_first_nsec <= i_stamp_nsec;
                            r_dsec <= '0;
                            r_dnsec <= '0;
                        end else begin
                            r_dsec <= $signed({1'b0, i_stamp_sec}) - $signed({1'b0, r_first_sec});
                            r_dnsec <= $signed({2'b0, i_stamp_nsec})
                                     - $signed({2'b0, r_first_nsec});
                            if (i_event_kind == KIND_MOVE && r_last_kind == KIND_MOVE) begin
                                r_step <= 1'b1;
                                r_pairs <= r_pairs + 16'd1;
                                if (r_total >= 16'd2 && opp) r_revs <= r_revs + 16'd1;
                            end
                        end
                        r_adx <= dx1[DW-1] ? (DW-1)'(-dx1) : (DW-1)'(dx1);
                        r_ady <= dy1[DW-1] ? (DW-1)'(-dy1) : (DW-1)'(dy1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sq <= 66'(r_adx * r_adx) + 66'(r_ady * r_ady);
                    r_elapsed <= 64'(r_dsec * $signed({1'b0, NS_PER_SEC}))
                               + 64'(r_dnsec);
                    r_bx <= r_lx; r_by <= r_ly;
                    r_lx <= r_x; r_ly <= r_y;
                    r_last_kind <= r_kind;
                    r_total <= r_total + 16'd1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!i_job_full) begin
                        if (done) begin
                            r_total <= '0; r_first_sec <= '0; r_first_nsec <= '0;
                            r_last_kind <= '0; r_lx <= '0; r_ly <= '0;
                            r_bx <= '0; r_by <= '0; r_pairs <= '0; r_revs <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/ptsa_queue.sv
// small job queue between front and back end
module ptsa_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptsa_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ptsa_pkg::t_job o_job
);
    import ptsa_pkg::*;

    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

FILE: src/ptsa_back.sv
// back end: shared shift-subtract unit for step length, speed and accuracy
module ptsa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  ptsa_pkg::t_job             i_job,
    output logic                       o_job_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [ptsa_pkg::SPD_W-1:0] o_speed,
    output logic signed [ptsa_pkg::ACC_W-1:0] o_accuracy
);
    import ptsa_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SQRT  = 8'b00000010,
        S_ACC   = 8'b00000100,
        S_SPM   = 8'b00001000,
        S_SPD   = 8'b00010000,
        S_ACCD  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_POP   = 8'b10000000
    } t_state;

    t_state r_state;
    t_job   r_job;
    logic [39:0] r_dist;
    logic [97:0] r_rad;     // radicand shifted, 2*(33+16) bits
    logic [49:0] r_root;
    logic [51:0] r_srem;
    logic [6:0]  r_cnt;
    logic [69:0] r_num;     // dist * 1e9
    logic [64:0] r_drem;
    logic [69:0] r_q;
    logic [32:0] r_anum;
    logic [16:0] r_aq;
    logic [16:0] r_arem;
    logic [16:0] r_aden;
    logic [39:0] r_speed;

    // sqrt step
    logic [51:0] s_rem, s_t;
    assign s_rem = {r_srem[49:0], r_rad[97:96]};
    assign s_t   = {r_root, 2'b01};

    // long divide step
    logic [64:0] d_rem;
    assign d_rem = {r_drem[63:0], r_num[69]};

    logic [16:0] a_rem;
    assign a_rem = {r_arem[15:0], r_anum[32]};

    logic [40:0] d_sum;
    assign d_sum = {1'b0, r_dist} + 41'(r_root);

    assign o_job_pop  = (r_state == S_POP);
    assign o_valid    = (r_state == S_OUT);
    assign o_speed    = r_speed;
    assign o_accuracy = ONE_Q16 - ACC_W'(r_aq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dist  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job  <= i_job;
                        r_rad  <= 98'(i_job.radicand) << (2 * FRAC_BITS);
                        r_root <= '0; r_srem <= '0; r_cnt <= 7'd0;
                        r_state <= i_job.do_step ? S_SQRT : S_SPM;
                    end
                end
                S_SQRT: begin
                    r_rad <= r_rad << 2;
                    if (s_rem >= s_t) begin
                        r_srem <= s_rem - s_t;
                        r_root <= {r_root[48:0], 1'b1};
                    end else begin
                        r_srem <= s_rem;
                        r_root <= {r_root[48:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd48) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_dist  <= d_sum[40] ? '1 : d_sum[39:0];
                    r_state <= S_SPM;
                end
                S_SPM: begin
                    if (!r_job.do_report) begin
                        // no report: the distance is cleared only if the trajectory ends
                        if (r_job.do_end) r_dist <= '0;
                        r_state <= S_POP;
                    end else begin
                        r_num  <= 70'(r_dist) * 70'(NS_PER_SEC);
                        r_drem <= '0; r_q <= '0; r_cnt <= 7'd0;
                        r_anum <= {r_job.reversals, 17'd0} >> 1;
                        r_aden <= 17'(r_job.move_pairs) - 17'd1;
                        r_arem <= '0; r_aq <= '0;
                        r_state <= S_SPD;
                    end
                end
                S_SPD: begin
                    r_num <= r_num << 1;
                    if (d_rem >= {1'b0, r_job.elapsed}) begin
                        r_drem <= d_rem - {1'b0, r_job.elapsed};
                        r_q <= {r_q[68:0], 1'b1};
                    end else begin
                        r_drem <= d_rem;
                        r_q <= {r_q[68:0], 1'b0};
                    end
                    // accuracy divide shares the step counter
                    if (r_cnt < 7'd33) begin
                        r_anum <= r_anum << 1;
                        if (a_rem >= r_aden) begin
                            r_arem <= a_rem - r_aden;
                            r_aq <= {r_aq[15:0], 1'b1};
                        end else begin
                            r_arem <= a_rem;
                            r_aq <= {r_aq[15:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd69) r_state <= S_ACCD;
                end
                S_ACCD: begin
                    if (!r_job.elapsed_pos || !r_job.any_moves) r_speed <= '0;
                    else if (r_q[69:40] != '0) r_speed <= '1;
                    else r_speed <= r_q[39:0];
                    if (r_job.move_pairs < 16'd2) r_aq <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_dist <= '0;
                        r_state <= S_POP;
                    end
                end
                S_POP: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/pointer_trajectory_speed_accuracy.sv
// top level of the pointer trajectory speed and accuracy meter
// Pointer events are taken one at a time; the front end passes each event through its
// S_IDLE, S_MUL and S_DONE states to update trajectory state and do three multiplies,
// then hands a job to a two-entry queue, waiting while the queue is full. The back end
// runs one shift-subtract unit: a step length takes one root bit per cycle, and the speed
// and accuracy divides follow when a trajectory is reported; it takes one job at a time.
module pointer_trajectory_speed_accuracy #(
    parameter int COORD_WIDTH = ptsa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptsa_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_event_kind,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic [31:0]                   i_stamp_sec,
    input  logic [29:0]                   i_stamp_nsec,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ptsa_pkg::SPD_W-1:0]    o_speed,
    output logic signed [ptsa_pkg::ACC_W-1:0] o_accuracy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ptsa_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [ptsa_pkg::DUR_W-1:0]    i_cfg_data
);
    import ptsa_pkg::*;

    logic [DUR_W-1:0] r_max_dur, r_min_dur;
    logic [EVT_W-1:0] r_max_evt;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dur <= MAX_DUR_RST;
            r_min_dur <= MIN_DUR_RST;
            r_max_evt <= MAX_EVT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_DUR: r_max_dur <= i_cfg_data;
                REG_MIN_DUR: r_min_dur <= i_cfg_data;
                REG_MAX_EVT: r_max_evt <= i_cfg_data[EVT_W-1:0];
                default: ;
            endcase
        end
    end

    t_job f_job, q_job;
    logic f_push, q_full, q_valid, q_pop;

    ptsa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_event_kind(i_event_kind), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_stamp_sec(i_stamp_sec), .i_stamp_nsec(i_stamp_nsec),
        .i_max_dur(r_max_dur), .i_min_dur(r_min_dur), .i_max_evt(r_max_evt),
        .o_job_valid(f_push), .o_job(f_job), .i_job_full(q_full)
    );

    ptsa_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(f_push), .i_job(f_job), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_job(q_job)
    );

    ptsa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(q_valid), .i_job(q_job), .o_job_pop(q_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_speed(o_speed), .o_accuracy(o_accuracy)
    );
endmodule

FILE: sim/tb_top.sv
// testbench for the pointer trajectory speed and accuracy meter
`timescale 1ns / 1ps

module tb_top;
    import ptsa_pkg::*;

    localparam logic [1:0] KIND_CLICK = 2'd1;
    localparam logic [1:0] KIND_WHEEL = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [SPD_W-1:0] SPD_SAT = '1;
    localparam longint NS_SEC = 1000000000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 300;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [1:0] i_event_kind;
    logic signed [15:0] i_pos_x, i_pos_y;
    logic [31:0] i_stamp_sec;
    logic [29:0] i_stamp_nsec;
    logic [SPD_W-1:0] o_speed;
    logic signed [ACC_W-1:0] o_accuracy;
    logic i_cfg_valid, o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index;
    logic [DUR_W-1:0] i_cfg_data;

    pointer_trajectory_speed_accuracy u_dut (.*);

    typedef struct {
        logic [SPD_W-1:0] speed;
        logic [ACC_W-1:0] acc;
    } t_meas;

    typedef struct {
        logic [1:0] kind;
        logic signed [15:0] x, y;
        logic [31:0] sec;
        logic [29:0] nsec;
        bit has_exp;
        logic [SPD_W-1:0] speed;
        logic [ACC_W-1:0] acc;
    } t_ev_row;

    t_meas meas_q[$];
    int errors = 0;
    int quiet_cycles = 0;
    bit calm = 0;
    int rcv_wait = 0;

    // meter model state
    logic [DUR_W-1:0] cfg_max_dur, cfg_min_dur;
    logic [EVT_W-1:0] cfg_max_evt;
    logic [15:0] trj_events, trj_pairs, trj_revs;
    longint trj_first_sec, trj_first_nsec;
    logic [1:0] trj_last_kind;
    logic signed [15:0] last_x, last_y, prev_x, prev_y;
    logic [SPD_W-1:0] trj_dist;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_q(logic [63:0] v);
        logic [63:0] rem, root, t;
        rem = 0;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
            root = root << 1;
            t = (root << 1) | 64'd1;
            if (rem >= t) begin
                rem = rem - t;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic bit opposite(longint a, longint b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    task automatic clear_trj();
        trj_events = 0; trj_first_sec = 0; trj_first_nsec = 0; trj_last_kind = 0;
        last_x = 0; last_y = 0; prev_x = 0; prev_y = 0;
        trj_dist = 0; trj_pairs = 0; trj_revs = 0;
    endtask

    task automatic track_event(input logic [1:0] kind, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic [31:0] sec,
                               input logic [29:0] nsec, output bit got, output t_meas m);
        longint dx1, dy1, dx0, dy0, el, acc;
        logic [63:0] len;
        logic [64:0] dsum;
        logic [127:0] num, q;
        logic [15:0] n;
        got = 0;
        m.speed = 0;
        m.acc = 0;
        el = 0;
        if (trj_events == 0) begin
            trj_first_sec = longint'({32'd0, sec});
            trj_first_nsec = longint'({34'd0, nsec});
        end else if (kind == KIND_MOVE && trj_last_kind == KIND_MOVE) begin
            dx1 = longint'(x) - longint'(last_x);
            dy1 = longint'(y) - longint'(last_y);
            len = root_q(64'(dx1 * dx1 + dy1 * dy1) << (2 * FRAC_BITS_DEF));
            dsum = 65'(trj_dist) + 65'(len);
            trj_dist = (dsum > 65'(SPD_SAT)) ? SPD_SAT : dsum[SPD_W-1:0];
            trj_pairs = trj_pairs + 16'd1;
            if (trj_events >= 2) begin
                dx0 = longint'(last_x) - longint'(prev_x);
                dy0 = longint'(last_y) - longint'(prev_y);
                if (opposite(dx1, dx0) || opposite(dy1, dy0))
                    trj_revs = trj_revs + 16'd1;
            end
        end
        n = trj_events + 16'd1;
        if (n > 1)
            el = (longint'({32'd0, sec}) - trj_first_sec) * NS_SEC
               + (longint'({34'd0, nsec}) - trj_first_nsec);
        prev_x = last_x; prev_y = last_y;
        last_x = x; last_y = y;
        trj_last_kind = kind;
        trj_events = n;
        if (kind != KIND_MOVE || el > longint'({30'd0, cfg_max_dur}) || n >= cfg_max_evt) begin
            if (el >= longint'({30'd0, cfg_min_dur}) && n > 1) begin
                if (el > 0 && trj_pairs > 0) begin
                    num = 128'(trj_dist) * 128'(NS_SEC);
                    q = num / 128'(el);
                    m.speed = (q > 128'(SPD_SAT)) ? SPD_SAT : q[SPD_W-1:0];
                end
                acc = 65536;
                if (trj_pairs > 1)
                    acc = 65536 - longint'((64'(trj_revs) << 16) / 64'(trj_pairs - 16'd1));
                m.acc = acc[ACC_W-1:0];
                got = 1;
            end
            clear_trj();
        end
    endtask

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    task automatic send_event(input t_ev_row r);
        int gap;
        bit got;
        t_meas m;
        gap = draw_wait();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_event_kind <= r.kind;
        i_pos_x <= r.x;
        i_pos_y <= r.y;
        i_stamp_sec <= r.sec;
        i_stamp_nsec <= r.nsec;
        do @(posedge i_clk); while (o_stall);
        track_event(r.kind, r.x, r.y, r.sec, r.nsec, got, m);
        if (got) begin
            if (r.has_exp) begin
                m.speed = r.speed;
                m.acc = r.acc;
            end
            meas_q.push_back(m);
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        i_valid <= 0;
        while (meas_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_MAX_DUR: cfg_max_dur = data;
            REG_MIN_DUR: cfg_min_dur = data;
            REG_MAX_EVT: cfg_max_evt = data[EVT_W-1:0];
            default: ;
        endcase
    endtask

    // receiver: random stall per word
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            rcv_wait = draw_wait();
            if (meas_q.size() == 0) begin
                $display("%0t: unexpected result speed %0d accuracy %0d",
                         $time, o_speed, o_accuracy);
                errors++;
            end else begin
                if (o_speed !== meas_q[0].speed) begin
                    $display("%0t: speed expected %0d actual %0d",
                             $time, meas_q[0].speed, o_speed);
                    errors++;
                end
                if (o_accuracy !== meas_q[0].acc) begin
                    $display("%0t: accuracy expected %0d actual %0d",
                             $time, $signed(meas_q[0].acc), o_accuracy);
                    errors++;
                end
                void'(meas_q.pop_front());
            end
        end else if (rcv_wait > 0) begin
            rcv_wait--;
        end
        i_stall <= (rcv_wait != 0);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic run_phase(input int count, input longint step_max);
        t_ev_row r;
        longint now_ns;
        int sel;
        now_ns = longint'($urandom_range(0, 1000)) * NS_SEC + $urandom_range(0, 999999999);
        r.x = 0;
        r.y = 0;
        r.has_exp = 0;
        r.speed = 0;
        r.acc = 0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) calm = !calm;
            r.kind = ($urandom_range(0, 99) < 85) ? KIND_MOVE : 2'($urandom_range(1, 3));
            sel = $urandom_range(0, 99);
            if (sel < 88) begin
                r.x = r.x + 16'($signed($urandom_range(0, 400)) - 200);
                r.y = r.y + 16'($signed($urandom_range(0, 400)) - 200);
            end else if (sel < 95) begin
                r.x = 16'($urandom);
                r.y = 16'($urandom);
            end else begin
                r.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                r.y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            end
            now_ns = now_ns + longint'($urandom_range(0, 32'(step_max)));
            if ($urandom_range(0, 99) < 5) begin
                // broken timing: arbitrary stamp, raw nanoseconds
                r.sec = $urandom;
                r.nsec = 30'($urandom);
                if ($urandom_range(0, 1)) now_ns = longint'({32'd0, r.sec}) * NS_SEC;
            end else begin
                r.sec = 32'(now_ns / NS_SEC);
                r.nsec = 30'(now_ns % NS_SEC);
            end
            send_event(r);
        end
    endtask

    t_ev_row dir_rows[16];

    initial begin
        i_rst_n <= 0;
        i_valid <= 0;
        i_event_kind <= 0;
        i_pos_x <= 0;
        i_pos_y <= 0;
        i_stamp_sec <= 0;
        i_stamp_nsec <= 0;
        i_stall <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= 0;
        i_cfg_data <= 0;
        cfg_max_dur = MAX_DUR_RST;
        cfg_min_dur = MIN_DUR_RST;
        cfg_max_evt = MAX_EVT_RST;
        clear_trj();

        dir_rows[0]  = '{KIND_MOVE, 16'sd0, 16'sd0, 32'd0, 30'd0, 0, 0, 0};
        dir_rows[1]  = '{KIND_MOVE, 16'sd3, 16'sd4, 32'd0, 30'd500000000, 0, 0, 0};
        // step of 5 over one second, one move pair
        dir_rows[2]  = '{KIND_CLICK, 16'sd3, 16'sd4, 32'd1, 30'd0, 1, 40'd1280, 18'd65536};
        dir_rows[3]  = '{KIND_MOVE, 16'sh8000, 16'sh8000, 32'd10, 30'd0, 0, 0, 0};
        dir_rows[4]  = '{KIND_MOVE, 16'sh7fff, 16'sh7fff, 32'd11, 30'd0, 0, 0, 0};
        dir_rows[5]  = '{KIND_MOVE, 16'sh8000, 16'sh7fff, 32'd12, 30'd0, 0, 0, 0};
        dir_rows[6]  = '{KIND_WHEEL, 16'sd0, 16'sd0, 32'd12, 30'd0, 0, 0, 0};
        // too short to report
        dir_rows[7]  = '{KIND_MOVE, 16'sd5, 16'sd5, 32'd20, 30'd0, 0, 0, 0};
        dir_rows[8]  = '{KIND_OTHER, 16'sd5, 16'sd5, 32'd20, 30'd500000000, 0, 0, 0};
        // ends on duration
        dir_rows[9]  = '{KIND_MOVE, 16'sd0, 16'sd0, 32'd30, 30'd0, 0, 0, 0};
        dir_rows[10] = '{KIND_MOVE, 16'sd100, -16'sd100, 32'd41, 30'd0, 0, 0, 0};
        dir_rows[11] = '{KIND_CLICK, 16'sd0, 16'sd0, 32'd50, 30'd0, 0, 0, 0};
        // negative elapsed time
        dir_rows[12] = '{KIND_MOVE, 16'sd1, 16'sd1, 32'd60, 30'h3fffffff, 0, 0, 0};
        dir_rows[13] = '{KIND_CLICK, 16'sd1, 16'sd1, 32'd59, 30'd0, 0, 0, 0};
        dir_rows[14] = '{KIND_MOVE, 16'sd7, -16'sd7, 32'hffffffff, 30'd999999999, 0, 0, 0};
        dir_rows[15] = '{KIND_WHEEL, 16'sd7, -16'sd7, 32'hffffffff, 30'd999999999, 0, 0, 0};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_event(dir_rows[i]);

        run_phase(220, 400000000);
        write_reg(REG_MAX_DUR, '1);
        write_reg(REG_MIN_DUR, 0);
        write_reg(REG_MAX_EVT, 16'hffff);
        write_reg(REG_SPARE, 34'($urandom));
        run_phase(220, 3);
        write_reg(REG_MAX_DUR, 0);
        write_reg(REG_MAX_EVT, 2);
        run_phase(200, 2);
        write_reg(REG_MAX_DUR, 500000000);
        write_reg(REG_MIN_DUR, 100000000);
        write_reg(REG_MAX_EVT, 8);
        run_phase(220, 100000000);
        write_reg(REG_MIN_DUR, '1);
        write_reg(REG_MAX_EVT, 0);
        run_phase(100, 100000000);
        write_reg(REG_MAX_EVT, 1);
        run_phase(40, 100000000);
        write_reg(REG_MAX_DUR, 3000000000);
        write_reg(REG_MIN_DUR, 0);
        write_reg(REG_MAX_EVT, 40);
        run_phase(220, 200000000);
        write_reg(REG_MAX_DUR, MAX_DUR_RST);
        write_reg(REG_MIN_DUR, MIN_DUR_RST);
        write_reg(REG_MAX_EVT, MAX_EVT_RST);
        run_phase(120, 400000000);

        i_valid <= 0;
        while (meas_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && meas_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
